// ----- sv/fat_short_name_parser_unit_assert.svh -----
// assertion macros for the fat short name parser checker
// expects clk_i and rst_ni in the scope of each use
`ifndef FAT_SHORT_NAME_PARSER_UNIT_ASSERT_SVH
`define FAT_SHORT_NAME_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define FSNP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FSNP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fsnp_pkg.sv -----
// shared constants, types and helpers for the fat short name parser
// used by the top level and its checker, no dependencies
`default_nettype none

package fsnp_pkg;

  localparam int unsigned NameLen = 11;
  localparam int unsigned BaseLen = 8;

  localparam logic [7:0] SpaceByte = 8'h20;
  localparam logic [7:0] HighByte  = 8'h80;
  localparam logic [7:0] DotByte   = 8'h2e;
  localparam logic [7:0] SlashByte = 8'h2f;
  localparam logic [7:0] NulByte   = 8'h00;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerZ    = 8'h7a;
  localparam logic [7:0] CaseDelta = 8'h20;

  localparam logic [3:0] BasePos = 4'(BaseLen);
  localparam logic [3:0] NamePos = 4'(NameLen);

  typedef enum logic [1:0] {
    STATUS_SLASH = 2'd0,
    STATUS_FINAL = 2'd1,
    STATUS_BAD   = 2'd2
  } status_e;

  // punctuation that a short name may not hold
  function automatic logic is_bad_char(input logic [7:0] c);
    logic bad;
    unique case (c)
      8'h2b, 8'h2c, 8'h3b, 8'h3d, 8'h5b, 8'h5d, 8'h2a,
      8'h3c, 8'h3a, 8'h3e, 8'h7c, 8'h22, 8'h3f, 8'h5c: bad = 1'b1;
      default: bad = 1'b0;
    endcase
    return bad;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fat_short_name_parser_unit.sv -----
// Path byte stream to 8.3 short name converter.
// Uses fsnp_pkg for constants, status codes and the forbidden character test.
//
// Slave channel s_axis_*: one path byte per transaction, zero ends the path.
// Master channel m_axis_*: one short name per finished component; tdata holds
// the eight base bytes (bits 63:0) and three extension bytes (bits 87:64),
// first character in the top byte of each part; tuser carries the status
// (slash-ended, final component, bad name). Bad names come with zero data.
// Bytes of a path after a bad component are dropped up to its zero byte.
// cfg_we_i/cfg_wdata_i write the strict check flag; write it only while idle.
// A byte accepted into the input register is decoded from there; its result enters
// the output register, or the skid register while the output is held.
// Throughput: one byte per cycle; the input stage, the component state and a
// two-entry output buffer (output register plus skid register) each take one
// transaction a cycle. When the receiver stalls, bytes keep flowing until a
// second result waits in the skid register and the input register holds one
// more byte, then s_axis_tready_o drops.
// Reset clears the name to spaces, leaves skip mode, sets strict checking and
// empties all stages.
`default_nettype none

module fat_short_name_parser_unit
  import fsnp_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_wdata_i,      // strict_check
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] path_char
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // [63:0] name_main, [87:64] name_ext
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  typedef struct packed {
    logic [63:0] name_main;
    logic [23:0] name_ext;
    status_e     status;
  } result_t;

  logic        strict_q;
  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic [7:0]  store_q [NameLen];
  logic [7:0]  store_d [NameLen];
  logic [3:0]  pos_q, pos_d;
  logic        ext_q, ext_d;
  logic        skip_q, skip_d;
  logic        advance;
  logic        emit;
  result_t     res;
  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic [7:0]  up_char;
  logic [3:0]  limit;

  assign advance         = in_valid_q && !skid_valid_q;
  assign s_axis_tready_o = !in_valid_q || !skid_valid_q;

  assign limit   = ext_q ? NamePos : BasePos;
  assign up_char = (in_char_q >= LowerA && in_char_q <= LowerZ) ?
                   (in_char_q - CaseDelta) : in_char_q;

  always_comb begin
    store_d = store_q;
    pos_d   = pos_q;
    ext_d   = ext_q;
    skip_d  = skip_q;
    emit    = 1'b0;
    res     = '{name_main: '0, name_ext: '0, status: STATUS_BAD};
    for (int k = 0; k < BaseLen; k++) begin
      res.name_main[8*(BaseLen-1-k) +: 8] = store_q[k];
    end
    for (int k = 0; k < NameLen - BaseLen; k++) begin
      res.name_ext[8*(NameLen-BaseLen-1-k) +: 8] = store_q[BaseLen+k];
    end
    if (advance) begin
      priority if (skip_q) begin
        if (in_char_q == NulByte) begin
          skip_d = 1'b0;
        end
      end else if (in_char_q == NulByte && pos_q != '0) begin
        emit       = 1'b1;
        res.status = STATUS_FINAL;
      end else if (in_char_q == SlashByte) begin
        emit       = 1'b1;
        res.status = STATUS_SLASH;
      end else if (in_char_q == NulByte || (in_char_q == DotByte && pos_q == '0)
                   || (in_char_q == DotByte && strict_q && ext_q)) begin
        emit   = 1'b1;
        skip_d = (in_char_q != NulByte);
      end else if (in_char_q == DotByte) begin
        pos_d = BasePos;
        ext_d = 1'b1;
      end else if (pos_q >= limit || (strict_q && (is_bad_char(in_char_q)
                   || in_char_q <= SpaceByte || in_char_q >= HighByte))) begin
        emit   = 1'b1;
        skip_d = 1'b1;
      end else begin
        store_d[pos_q] = up_char;
        pos_d          = pos_q + 4'd1;
      end
      // error results carry an empty name
      if (emit && res.status == STATUS_BAD) begin
        res.name_main = '0;
        res.name_ext  = '0;
      end
      // any result, or the end of a skipped path, starts a fresh component
      if (emit || (skip_q && in_char_q == NulByte)) begin
        for (int k = 0; k < NameLen; k++) begin
          store_d[k] = SpaceByte;
        end
        pos_d = '0;
        ext_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q     <= 1'b1;
      in_valid_q   <= 1'b0;
      pos_q        <= '0;
      ext_q        <= 1'b0;
      skip_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      for (int k = 0; k < NameLen; k++) begin
        store_q[k] <= SpaceByte;
      end
    end else begin
      if (cfg_we_i) begin
        strict_q <= cfg_wdata_i[0];
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
        in_char_q  <= s_axis_tdata_i;
      end
      store_q <= store_d;
      pos_q   <= pos_d;
      ext_q   <= ext_d;
      skip_q  <= skip_d;
      if (out_valid_q && !m_axis_tready_i) begin
        // output held: a new result parks in the skid register
        if (emit) begin
          skid_q       <= res;
          skid_valid_q <= 1'b1;
        end
      end else if (skid_valid_q) begin
        out_q        <= skid_q;
        out_valid_q  <= 1'b1;
        skid_valid_q <= emit;
        if (emit) begin
          skid_q <= res;
        end
      end else begin
        out_q       <= res;
        out_valid_q <= emit;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.name_ext, out_q.name_main};
  assign m_axis_tuser_o  = out_q.status;

endmodule

`default_nettype wire

// ----- sv/fsnp_checker.sv -----
// port-level checker for fat_short_name_parser_unit, bound to the top level
// uses fsnp_pkg status codes and the assertion macros header
`default_nettype none

`include "fat_short_name_parser_unit_assert.svh"

module fsnp_checker
  import fsnp_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [87:0] m_axis_tdata_o,
  input wire [1:0]  m_axis_tuser_o
);

  `FSNP_ASSERT_NOW(a_bad_name_zero, m_axis_tvalid_o && m_axis_tuser_o == STATUS_BAD, m_axis_tdata_o == '0, "bad name result carries name bytes")
  `FSNP_ASSERT_NOW(a_first_upper, m_axis_tvalid_o, !(m_axis_tdata_o[63:56] >= 8'h61 && m_axis_tdata_o[63:56] <= 8'h7a), "lower-case letter in short name")
  `FSNP_ASSERT_NOW(a_stall_cause, !s_axis_tready_o, m_axis_tvalid_o, "input stalled with no result pending")
  `FSNP_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind fat_short_name_parser_unit fsnp_checker u_fsnp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
